### rtl/core/rpnh_pkg.sv
// ---------------------------------------------------------------------------
// rpnh_pkg
// shared types and constants of the random node picker with health records
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package rpnh_pkg;

    localparam int NODES  = 32;
    localparam int IDX_W  = 5;
    localparam int CNT_W  = 6;
    localparam int WORD_W = 32;
    localparam logic [WORD_W-1:0] SAT_MAX = {WORD_W{1'b1}};

    typedef enum logic [1:0] {
        OP_SELECT = 2'd0,
        OP_REPORT = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FALLBACK = 2'd1,
        ST_NO_NODES = 2'd2,
        ST_BAD      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CFG_NODE_COUNT  = 3'd0,
        CFG_RETRY       = 3'd1,
        CFG_BURST_WIN   = 3'd2,
        CFG_BURST_FAILS = 3'd3,
        CFG_CHECK       = 3'd4,
        CFG_MIN_CALLS   = 3'd5,
        CFG_RATIO       = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD_START,
        S_SCAN,
        S_MOD_PICK,
        S_FALLBACK_SUM,
        S_REPORT,
        S_RATIO,
        S_DONE
    } state_t;

    typedef struct packed {
        logic               start;
        logic [WORD_W-1:0]  dividend;
        logic [CNT_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [CNT_W-1:0]   rem;
    } div_rsp_t;

    function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? SAT_MAX : s[WORD_W-1:0];
    endfunction

endpackage

### rtl/core/rpnh_mod_unit.sv
// ---------------------------------------------------------------------------
// rpnh_mod_unit
// bit-serial remainder of a 32-bit word by a small node count
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rpnh_mod_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  rpnh_pkg::div_req_t req,
    output rpnh_pkg::div_rsp_t rsp
);
    import rpnh_pkg::*;

    logic [WORD_W-1:0] word_reg, word_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W+1:0]  trial;

    always_comb
    begin
        word_next = word_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, word_reg[WORD_W-1]};
        if (req.start)
        begin
            word_next = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = 6'(WORD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            word_next = {word_reg[WORD_W-2:0], 1'b0};
            if (trial >= {2'b00, dvs_reg})
                rem_next = (CNT_W+1)'(trial - {2'b00, dvs_reg});
            else
                rem_next = (CNT_W+1)'(trial);
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg[CNT_W-1:0];
endmodule

### rtl/core/rpnh_ratio_unit.sv
// ---------------------------------------------------------------------------
// rpnh_ratio_unit
// shift-add product of threshold and call total, one bit a cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module rpnh_ratio_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [8:0]                   ratio,
    input  logic [rpnh_pkg::WORD_W:0]    total,
    output logic                         done,
    output logic [rpnh_pkg::WORD_W+9:0]  product
);
    import rpnh_pkg::*;

    logic [WORD_W+9:0] acc_reg, acc_next;
    logic [WORD_W+9:0] mcand_reg, mcand_next;
    logic [8:0]        mplier_reg, mplier_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next, done_reg, done_next;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = (WORD_W+10)'(total);
            mplier_next = ratio;
            cnt_next    = 4'd9;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = {mcand_reg[WORD_W+8:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[8:1]};
            cnt_next    = cnt_reg - 4'd1;
            if (cnt_reg == 4'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

### rtl/core/random_pick_with_node_health_core.sv
// ---------------------------------------------------------------------------
// random_pick_with_node_health_core
// random node picker with per-node failure tracking and retry probing
//
//  channel   signals                                        direction
//  item in   start, op, node_index, failed, now_time,        in
//            rand_start, rand_pick (busy goes out)
//  result    done, chosen_node, status                      out
//  config    cfg_valid, cfg_index, cfg_data (cfg_ready out) in
//
//  select: the bit-serial remainder unit reduces rand_start to a start
//  position, the scan then tests one node after another from there, and
//  when no node qualifies a second remainder, of rand_pick, gives the
//  fallback offset
//  report: the error ratio is evaluated when due (shift-add product)
//  records reset together with rst_n; no clearing pass
//  done pulses for one cycle; the receiver cannot stall
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module random_pick_with_node_health_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [4:0]  node_index,
    input  logic        failed,
    input  logic [31:0] now_time,
    input  logic [31:0] rand_start,
    input  logic [31:0] rand_pick,
    output logic        done,
    output logic [4:0]  chosen_node,
    output logic [1:0]  status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import rpnh_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0] node_count_reg;
    logic [15:0] retry_reg, burst_win_reg, burst_fails_reg, check_reg, min_calls_reg;
    logic [8:0]  ratio_reg;

    logic [NODES-1:0]  up_reg;
    logic [WORD_W-1:0] succ_reg [NODES];
    logic [WORD_W-1:0] err_reg  [NODES];
    logic [WORD_W-1:0] run_reg  [NODES];
    logic [WORD_W-1:0] bdl_reg  [NODES];
    logic [WORD_W-1:0] wdl_reg  [NODES];
    logic [WORD_W-1:0] rdl_reg  [NODES];

    logic [IDX_W-1:0]  idx_reg;
    logic              fail_reg;
    logic [WORD_W-1:0] now_reg, pick_reg;
    logic [CNT_W-1:0]  n_reg, start_pos_reg, pos_reg, left_reg;
    logic [IDX_W-1:0]  chosen_reg;
    status_t           status_reg;
    logic              done_reg;

    div_req_t dreq;
    div_rsp_t drsp;
    logic     rstart;
    logic     rdone;
    logic [WORD_W+9:0] rprod;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W:0]   fsum;
    logic [IDX_W-1:0] pos_i;
    logic             probe_ok;
    logic [WORD_W:0]  total;
    logic [WORD_W+9:0] err_scaled;

    logic [WORD_W-1:0] now_retry, now_burst, now_check;
    logic [WORD_W-1:0] err_inc, succ_inc, run_inc, bdl_new;
    logic              burst_down, win_due, ratio_go;

    assign n_eff    = (node_count_reg > CNT_W'(NODES)) ? CNT_W'(NODES) : node_count_reg;
    assign pos_i    = pos_reg[IDX_W-1:0];
    assign probe_ok = up_reg[pos_i] || (now_reg >= rdl_reg[pos_i]);
    assign fsum     = {1'b0, start_pos_reg} + {1'b0, drsp.rem};
    assign err_scaled = {2'b00, err_reg[idx_reg], 8'd0};
    assign now_retry = sat_add(now_reg, {16'd0, retry_reg});
    assign now_burst = sat_add(now_reg, {16'd0, burst_win_reg});
    assign now_check = sat_add(now_reg, {16'd0, check_reg});

    assign err_inc    = sat_add(err_reg[idx_reg], 32'd1);
    assign succ_inc   = sat_add(succ_reg[idx_reg], 32'd1);
    assign run_inc    = sat_add(run_reg[idx_reg], 32'd1);
    assign bdl_new    = (run_reg[idx_reg] == '0) ? now_burst : bdl_reg[idx_reg];
    assign burst_down = fail_reg && (run_inc >= {16'd0, burst_fails_reg})
                        && (now_reg >= bdl_new);
    assign win_due    = (now_reg >= wdl_reg[idx_reg]);
    assign total      = {1'b0, succ_reg[idx_reg]} + {1'b0, err_inc};
    assign ratio_go   = up_reg[idx_reg] && fail_reg && !burst_down && win_due
                        && (total >= {17'd0, min_calls_reg});

    rpnh_mod_unit u_mod (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    rpnh_ratio_unit u_ratio (
        .clk(clk), .rst_n(rst_n), .start(rstart), .ratio(ratio_reg),
        .total(total), .done(rdone), .product(rprod)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_SELECT && n_eff != '0)
                        state_next = S_MOD_START;
                    else if (op == OP_REPORT)
                        state_next = S_REPORT;
                    else
                        state_next = S_DONE;
                end
            end
            S_MOD_START:    if (drsp.done) state_next = S_SCAN;
            S_SCAN:
            begin
                if (probe_ok)
                    state_next = S_DONE;
                else if (left_reg == CNT_W'(1))
                    state_next = S_MOD_PICK;
            end
            S_MOD_PICK:     if (drsp.done) state_next = S_FALLBACK_SUM;
            S_FALLBACK_SUM: state_next = S_DONE;
            S_REPORT:
            begin
                if (ratio_go)
                    state_next = S_RATIO;
                else
                    state_next = S_DONE;
            end
            S_RATIO:        if (rdone) state_next = S_DONE;
            S_DONE:         state_next = S_IDLE;
            default:        state_next = S_IDLE;
        endcase
    end

    // unit control
    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = rand_start;
        dreq.divisor  = n_eff;
        rstart        = 1'b0;
        unique case (state_reg)
            S_IDLE:     dreq.start = start && op == OP_SELECT && n_eff != '0;
            S_SCAN:
            begin
                dreq.start    = !probe_ok && left_reg == CNT_W'(1);
                dreq.dividend = pick_reg;
                dreq.divisor  = n_reg;
            end
            S_REPORT:   rstart = (state_next == S_RATIO);
            default:    dreq.start = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            node_count_reg  <= '0;
            retry_reg       <= 16'd30;
            burst_win_reg   <= 16'd5;
            burst_fails_reg <= 16'd5;
            check_reg       <= 16'd60;
            min_calls_reg   <= 16'd10;
            ratio_reg       <= 9'd128;
            up_reg          <= '1;
            for (int i = 0; i < NODES; i++)
            begin
                succ_reg[i] <= '0;
                err_reg[i]  <= '0;
                run_reg[i]  <= '0;
                bdl_reg[i]  <= '0;
                wdl_reg[i]  <= '0;
                rdl_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DONE);
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_NODE_COUNT:  node_count_reg  <= cfg_data[CNT_W-1:0];
                    CFG_RETRY:       retry_reg       <= cfg_data[15:0];
                    CFG_BURST_WIN:   burst_win_reg   <= cfg_data[15:0];
                    CFG_BURST_FAILS: burst_fails_reg <= cfg_data[15:0];
                    CFG_CHECK:       check_reg       <= cfg_data[15:0];
                    CFG_MIN_CALLS:   min_calls_reg   <= cfg_data[15:0];
                    CFG_RATIO:       ratio_reg       <= cfg_data[8:0];
                    default:         ratio_reg       <= ratio_reg;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start && op == OP_CLEAR)
                    begin
                        up_reg[node_index]   <= 1'b1;
                        succ_reg[node_index] <= '0;
                        err_reg[node_index]  <= '0;
                        run_reg[node_index]  <= '0;
                        bdl_reg[node_index]  <= '0;
                        wdl_reg[node_index]  <= '0;
                        rdl_reg[node_index]  <= '0;
                    end
                end
                S_SCAN:
                begin
                    if (probe_ok && !up_reg[pos_i])
                        rdl_reg[pos_i] <= now_retry;
                end
                S_REPORT:
                begin
                    if (!up_reg[idx_reg])
                    begin
                        if (!fail_reg)
                        begin
                            up_reg[idx_reg]   <= 1'b1;
                            succ_reg[idx_reg] <= 32'd1;
                            err_reg[idx_reg]  <= '0;
                            run_reg[idx_reg]  <= '0;
                            bdl_reg[idx_reg]  <= now_burst;
                            wdl_reg[idx_reg]  <= now_check;
                        end
                        else
                            err_reg[idx_reg] <= err_inc;
                    end
                    else if (fail_reg)
                    begin
                        run_reg[idx_reg] <= run_inc;
                        bdl_reg[idx_reg] <= bdl_new;
                        if (burst_down)
                        begin
                            up_reg[idx_reg]  <= 1'b0;
                            rdl_reg[idx_reg] <= now_retry;
                            err_reg[idx_reg] <= err_inc;
                        end
                        else if (win_due)
                        begin
                            wdl_reg[idx_reg] <= now_check;
                            if (ratio_go)
                                err_reg[idx_reg] <= err_inc;
                            else
                            begin
                                succ_reg[idx_reg] <= '0;
                                err_reg[idx_reg]  <= '0;
                            end
                        end
                        else
                            err_reg[idx_reg] <= err_inc;
                    end
                    else
                    begin
                        run_reg[idx_reg] <= '0;
                        if (win_due)
                        begin
                            wdl_reg[idx_reg]  <= now_check;
                            succ_reg[idx_reg] <= '0;
                            err_reg[idx_reg]  <= '0;
                        end
                        else
                            succ_reg[idx_reg] <= succ_inc;
                    end
                end
                S_RATIO:
                begin
                    if (rdone)
                    begin
                        if (err_scaled >= rprod)
                        begin
                            up_reg[idx_reg]  <= 1'b0;
                            rdl_reg[idx_reg] <= now_retry;
                        end
                        else
                        begin
                            succ_reg[idx_reg] <= '0;
                            err_reg[idx_reg]  <= '0;
                        end
                    end
                end
                default: up_reg <= up_reg;
            endcase
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_reg    <= node_index;
                    fail_reg   <= failed;
                    now_reg    <= now_time;
                    pick_reg   <= rand_pick;
                    n_reg      <= n_eff;
                    left_reg   <= n_eff;
                    chosen_reg <= '0;
                    if (op == OP_SELECT)
                        status_reg <= (n_eff == '0) ? ST_NO_NODES : ST_OK;
                    else if (op == OP_NONE)
                        status_reg <= ST_BAD;
                    else
                        status_reg <= ST_OK;
                end
            end
            S_MOD_START:
            begin
                start_pos_reg <= drsp.rem;
                pos_reg       <= drsp.rem;
            end
            S_SCAN:
            begin
                if (probe_ok)
                    chosen_reg <= pos_i;
                else
                begin
                    pos_reg  <= (pos_reg + CNT_W'(1) >= n_reg) ? '0 : pos_reg + CNT_W'(1);
                    left_reg <= left_reg - CNT_W'(1);
                end
            end
            S_FALLBACK_SUM:
            begin
                chosen_reg <= (fsum >= {1'b0, n_reg}) ? IDX_W'(fsum - {1'b0, n_reg})
                                                      : IDX_W'(fsum);
                status_reg <= ST_FALLBACK;
            end
            S_MOD_PICK:
            begin
                if (drsp.done)
                    chosen_reg <= '0;
            end
            default:
            begin
                chosen_reg <= chosen_reg;
            end
        endcase
    end

    assign done        = done_reg;
    assign chosen_node = chosen_reg;
    assign status      = status_reg;
endmodule

### tb/tb_random_pick_with_node_health_core.sv
// ---------------------------------------------------------------------------
// tb_random_pick_with_node_health_core
// self-checking bench for the random node picker with health records
//
// a queue of pending items feeds a clocked driver; a clocked monitor compares
// every result against a queue of predicted picks. the prediction keeps its
// own copy of the node records and registers, and mirrors each register write
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_random_pick_with_node_health_core;
    import rpnh_pkg::*;

    typedef struct {
        op_t         op;
        logic [4:0]  node_index;
        logic        failed;
        logic [31:0] now_time;
        logic [31:0] rand_start;
        logic [31:0] rand_pick;
    } req_t;

    typedef struct {
        logic [4:0] chosen_node;
        status_t    status;
    } pick_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [4:0]  node_index;
    logic        failed;
    logic [31:0] now_time;
    logic [31:0] rand_start;
    logic [31:0] rand_pick;
    logic        done;
    logic [4:0]  chosen_node;
    logic [1:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    random_pick_with_node_health_core DUT (.*);

    // predictor state
    logic [5:0]  p_node_count;
    logic [15:0] p_retry, p_burst_win, p_burst_fails, p_check, p_min_calls;
    logic [8:0]  p_ratio;
    logic        p_up [NODES];
    logic [31:0] p_succ [NODES];
    logic [31:0] p_err [NODES];
    logic [31:0] p_run [NODES];
    logic [31:0] p_burst_dl [NODES];
    logic [31:0] p_win_dl [NODES];
    logic [31:0] p_retry_dl [NODES];

    req_t  pending_items[$];
    pick_t expected_picks[$];
    int    errors = 0;
    int    n_sent = 0;
    int    n_checked = 0;
    int    n_fallback = 0;
    int    send_idle_pct = 0;
    logic  hold_off = 0;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void clear_node(int i);
        p_up[i] = 1'b1;
        p_succ[i] = '0;
        p_err[i] = '0;
        p_run[i] = '0;
        p_burst_dl[i] = '0;
        p_win_dl[i] = '0;
        p_retry_dl[i] = '0;
    endfunction

    function automatic void apply_report(int i, logic fl, logic [31:0] t);
        logic [33:0] total;
        if (!p_up[i])
        begin
            if (!fl)
            begin
                p_up[i] = 1'b1;
                p_succ[i] = 32'd1;
                p_err[i] = '0;
                p_run[i] = '0;
                p_burst_dl[i] = add_sat(t, p_burst_win);
                p_win_dl[i] = add_sat(t, p_check);
            end
            else
                p_err[i] = add_sat(p_err[i], 1);
            return;
        end
        if (fl)
        begin
            p_err[i] = add_sat(p_err[i], 1);
            if (p_run[i] == 0)
                p_burst_dl[i] = add_sat(t, p_burst_win);
            p_run[i] = add_sat(p_run[i], 1);
            if (p_run[i] >= p_burst_fails && t >= p_burst_dl[i])
            begin
                p_up[i] = 1'b0;
                p_retry_dl[i] = add_sat(t, p_retry);
                return;
            end
        end
        else
        begin
            p_succ[i] = add_sat(p_succ[i], 1);
            p_run[i] = '0;
        end
        if (t >= p_win_dl[i])
        begin
            p_win_dl[i] = add_sat(t, p_check);
            total = p_succ[i] + p_err[i];
            if (fl && total >= p_min_calls
                && ({8'd0, p_err[i]} << 8) >= 42'(p_ratio) * total)
            begin
                p_up[i] = 1'b0;
                p_retry_dl[i] = add_sat(t, p_retry);
            end
            else
            begin
                p_succ[i] = '0;
                p_err[i] = '0;
            end
        end
    endfunction

    function automatic pick_t predict_pick(req_t r);
        pick_t res;
        int n, first, pos;
        logic found;
        res.chosen_node = '0;
        res.status = ST_OK;
        case (r.op)
            OP_SELECT:
            begin
                n = p_node_count > NODES ? NODES : p_node_count;
                if (n == 0)
                    res.status = ST_NO_NODES;
                else
                begin
                    first = r.rand_start % n;
                    pos = first;
                    found = 1'b0;
                    for (int k = 0; k < n && !found; k++)
                    begin
                        if (p_up[pos] || r.now_time >= p_retry_dl[pos])
                        begin
                            if (!p_up[pos])
                                p_retry_dl[pos] = add_sat(r.now_time, p_retry);
                            res.chosen_node = 5'(pos);
                            found = 1'b1;
                        end
                        else
                            pos = (pos + 1) % n;
                    end
                    if (!found)
                    begin
                        res.chosen_node = 5'((first + r.rand_pick % n) % n);
                        res.status = ST_FALLBACK;
                    end
                end
            end
            OP_REPORT: apply_report(r.node_index, r.failed, r.now_time);
            OP_CLEAR: clear_node(r.node_index);
            default: res.status = ST_BAD;
        endcase
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            op <= '0;
            node_index <= '0;
            failed <= 1'b0;
            now_time <= '0;
            rand_start <= '0;
            rand_pick <= '0;
        end
        else if (!start || !busy)
        begin
            if (start)
            begin
                n_sent++;
                expected_picks.insert(expected_picks.size(),
                                      predict_pick('{op_t'(op), node_index, failed,
                                                    now_time, rand_start, rand_pick}));
            end
            if (pending_items.size() > 0 && !hold_off
                && $urandom_range(99, 0) >= send_idle_pct)
            begin
                req_t r;
                r = pending_items.pop_front();
                start <= 1'b1;
                op <= r.op;
                node_index <= r.node_index;
                failed <= r.failed;
                now_time <= r.now_time;
                rand_start <= r.rand_start;
                rand_pick <= r.rand_pick;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_picks.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                pick_t e;
                e = expected_picks.pop_front();
                n_checked++;
                if (e.status == ST_FALLBACK)
                    n_fallback++;
                if (chosen_node !== e.chosen_node)
                begin
                    $error("chosen_node expected %0d actual %0d", e.chosen_node, chosen_node);
                    errors++;
                end
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_NODE_COUNT: p_node_count = val[5:0];
            CFG_RETRY: p_retry = val[15:0];
            CFG_BURST_WIN: p_burst_win = val[15:0];
            CFG_BURST_FAILS: p_burst_fails = val[15:0];
            CFG_CHECK: p_check = val[15:0];
            CFG_MIN_CALLS: p_min_calls = val[15:0];
            CFG_RATIO: p_ratio = val[8:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || start || expected_picks.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic push(op_t o, int idx, logic fl, logic [31:0] t, logic [31:0] rs,
                        logic [31:0] rp);
        pending_items.insert(pending_items.size(), '{o, idx[4:0], fl, t, rs, rp});
    endtask

    // random phase: mostly reports around a slowly moving clock with occasional jumps, plus selects, clears and bad ops
    task automatic random_items(int count, int nodes_hint, ref logic [31:0] t);
        int r, idx;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99, 0);
            if ($urandom_range(9, 0) == 0)
                t = $urandom;
            else
                t = add_sat(t, $urandom_range(20, 0));
            idx = $urandom_range(nodes_hint > 0 ? nodes_hint - 1 : 31, 0);
            if ($urandom_range(9, 0) == 0)
                idx = $urandom_range(31, 0);
            if (r < 35)
                push(OP_SELECT, idx, 1'($urandom_range(1, 0)), t, $urandom, $urandom);
            else if (r < 90)
                push(OP_REPORT, idx, $urandom_range(99, 0) < 70, t, $urandom, $urandom);
            else if (r < 96)
                push(OP_CLEAR, idx, 1'($urandom_range(1, 0)), t, $urandom, $urandom);
            else
                push(OP_NONE, $urandom_range(31, 0), 1'($urandom_range(1, 0)), $urandom,
                     $urandom, $urandom);
        end
    endtask

    initial
    begin
        logic [31:0] t;
        cfg_valid = 1'b0;
        cfg_index = CFG_NODE_COUNT;
        cfg_data = '0;
        p_node_count = 0;
        p_retry = 30;
        p_burst_win = 5;
        p_burst_fails = 5;
        p_check = 60;
        p_min_calls = 10;
        p_ratio = 128;
        for (int i = 0; i < NODES; i++)
            clear_node(i);
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: no nodes, bad op, saturation, quick mark-down and probe
        push(OP_SELECT, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push(OP_NONE, 31, 1, 32'hFFFF_FFFF, 0, 0);
        push(OP_REPORT, 31, 0, 32'hFFFF_FFFF, 0, 0);
        push(OP_CLEAR, 31, 0, 0, 0, 0);
        drain();
        write_reg(CFG_NODE_COUNT, 32'hFFFF_FFE3);
        write_reg(CFG_RETRY, 32'hFFFF);
        write_reg(CFG_BURST_WIN, 0);
        write_reg(CFG_BURST_FAILS, 1);
        write_reg(CFG_CHECK, 0);
        write_reg(CFG_MIN_CALLS, 0);
        write_reg(CFG_RATIO, 256);
        for (int i = 0; i < 3; i++)
            push(OP_REPORT, i, 1, 32'hFFFF_FFF0, 0, 0);
        push(OP_SELECT, 0, 0, 100, 1, 7);
        for (int i = 3; i < 35; i++)
            push(OP_REPORT, i % 35, 1, 32'hFFFF_FFF0, 0, 0);
        push(OP_SELECT, 0, 0, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push(OP_SELECT, 0, 0, 32'hFFFF_FFFF, 5, 0);
        push(OP_REPORT, 3, 0, 10, 0, 0);
        push(OP_SELECT, 0, 0, 10, 3, 0);
        drain();

        t = 1000;
        send_idle_pct = 24;
        write_reg(CFG_NODE_COUNT, 4);
        write_reg(CFG_RETRY, 0);
        write_reg(CFG_BURST_WIN, 3);
        write_reg(CFG_BURST_FAILS, 3);
        write_reg(CFG_CHECK, 20);
        write_reg(CFG_MIN_CALLS, 4);
        write_reg(CFG_RATIO, 64);
        random_items(300, 4, t);
        drain();

        hold_off = 1'b1;
        send_idle_pct = 73;
        write_reg(CFG_NODE_COUNT, 1);
        write_reg(CFG_RETRY, 40);
        write_reg(CFG_RATIO, 0);
        write_reg(CFG_BURST_FAILS, 0);
        hold_off = 1'b0;
        random_items(250, 1, t);
        drain();

        send_idle_pct = 0;
        write_reg(CFG_NODE_COUNT, 32);
        write_reg(CFG_RETRY, 15);
        write_reg(CFG_BURST_WIN, 65535);
        write_reg(CFG_BURST_FAILS, 65535);
        write_reg(CFG_CHECK, 65535);
        write_reg(CFG_MIN_CALLS, 65535);
        write_reg(CFG_RATIO, 200);
        random_items(150, 32, t);
        drain();
        write_reg(CFG_NODE_COUNT, 9);
        write_reg(CFG_BURST_WIN, 2);
        write_reg(CFG_BURST_FAILS, 2);
        write_reg(CFG_CHECK, 5);
        write_reg(CFG_MIN_CALLS, 2);
        random_items(150, 9, t);
        drain();

        $display("run covered %0d items, %0d results checked, %0d fallback picks",
                 n_sent, n_checked, n_fallback);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
